@@ hw/rtl/tdmh_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and ordering function of the deadline timer queue
package tdmh_pkg;

    localparam int DL_W        = 63;
    localparam int ID_W        = 62;
    localparam int ORD_W       = 32;
    localparam int PEND_W      = 7;
    localparam int MAX_RESULTS = 64;
    localparam int POP_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_INSERTED = 2'd0,
        KIND_FULL     = 2'd1,
        KIND_EXPIRED  = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef struct packed {
        logic            action;
        logic [DL_W-1:0] deadline;
        logic [ID_W-1:0] task_id;
        logic [DL_W-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   expired_id;
        logic [DL_W-1:0]   expired_deadline;
        logic [PEND_W-1:0] pending;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [DL_W-1:0]  deadline;
        logic [ID_W-1:0]  task_id;
        logic [ORD_W-1:0] order;
    } t_entry;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_entry   fresh;
    } t_cell_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INSERT,
        ST_TICK
    } t_state;

    // a leaves before b: earlier deadline, ties by wrapping order stamp
    function automatic logic earlier(input t_entry a, input t_entry b);
        logic [ORD_W-1:0] diff;
        diff = a.order - b.order;
        if (a.deadline != b.deadline) begin
            return a.deadline < b.deadline;
        end
        return diff[ORD_W-1];
    endfunction

endpackage

@@ hw/rtl/tdmh_cell.sv @@
`timescale 1ns / 1ps
// one slot of the sorted timer row: holds an entry, shifts right on insert, left on pop
module tdmh_cell
    import tdmh_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_entry    i_prev,
    input  logic      i_prev_before,
    input  t_entry    i_next,
    output t_entry    o_entry,
    output logic      o_before
);

    t_entry r_entry;
    t_entry n_entry;

    always_comb begin
        // empty slots count as later than anything
        o_before = !i_valid || earlier(i_ctl.fresh, r_entry);
        n_entry  = r_entry;
        unique case (i_ctl.op)
            CELL_HOLD: begin
                n_entry = r_entry;
            end
            CELL_INSERT: begin
                if (o_before) begin
                    n_entry = i_prev_before ? i_prev : i_ctl.fresh;
                end
            end
            CELL_POP: begin
                n_entry = i_next;
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ hw/rtl/deadline_timer_min_heap.sv @@
`timescale 1ns / 1ps
// deadline timer queue: sorted row of cells, insert and tick sequencer, result register
//
// Timer queue ordered by absolute deadline, equal deadlines leaving in insertion order.
// An insert beat (action 0) stores deadline and task id and answers one result: inserted,
// or queue full when QUEUE_DEPTH entries are already held. A tick beat (action 1) carries
// the current time and answers one expired result per entry whose deadline is at or before
// it, earliest first, at most 64 per tick, with last set on the final one; if nothing is
// due it answers a single none-expired result. Results appear on o_result for exactly one
// cycle, marked by o_result_valid, and must be taken then: the receiver cannot stall.
// Timing: an insert moves from idle to the insert state and back to idle before the next
// accept; a tick that expires entries gives one result per cycle, since the cell row moves
// one entry out of its head each cycle.
// busy is high while an item is in work; start is taken only while busy is low.
module deadline_timer_min_heap
    import tdmh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_item,
    output logic      busy,
    output logic      o_result_valid,
    output t_out_item o_result
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // control state
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [ORD_W-1:0]   r_seq;
    logic [ORD_W-1:0]   n_seq;
    logic [POP_W-1:0]   r_pops;
    logic [POP_W-1:0]   n_pops;
    logic               r_out_valid;
    logic               n_out_valid;

    // payload registers
    t_in_item           r_item;
    t_out_item          r_out;
    t_out_item          n_out;

    // cell row
    t_cell_ctl          w_ctl;
    t_entry             w_entry  [QUEUE_DEPTH];
    logic               w_before [QUEUE_DEPTH];

    logic               accept;
    logic               head_due;
    logic               next_due;

    assign accept = start && (r_state == ST_IDLE);

    genvar k;
    generate
        for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
            t_entry w_prev;
            logic   w_prev_before;
            t_entry w_next;

            if (k == 0) begin : g_head
                assign w_prev        = w_ctl.fresh;
                assign w_prev_before = 1'b0;
            end else begin : g_body
                assign w_prev        = w_entry[k-1];
                assign w_prev_before = w_before[k-1];
            end

            if (k == QUEUE_DEPTH - 1) begin : g_tail
                assign w_next = w_entry[k];
            end else begin : g_inner
                assign w_next = w_entry[k+1];
            end

            tdmh_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_valid       (r_count > CNT_W'(k)),
                .i_prev        (w_prev),
                .i_prev_before (w_prev_before),
                .i_next        (w_next),
                .o_entry       (w_entry[k]),
                .o_before      (w_before[k])
            );
        end
    endgenerate

    // head of the row is the earliest entry; the one behind it is the next to leave
    assign head_due = (r_count != '0) && (w_entry[0].deadline <= r_item.now_time);
    assign next_due = (r_count > CNT_W'(1))
                   && (w_entry[1].deadline <= r_item.now_time)
                   && (POP_W'(r_pops + 1'b1) < POP_W'(MAX_RESULTS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_seq       <= '0;
            r_pops      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_seq       <= n_seq;
            r_pops      <= n_pops;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        r_out <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_seq       = r_seq;
        n_pops      = r_pops;
        n_out_valid = 1'b0;
        n_out       = r_out;
        w_ctl.op    = CELL_HOLD;

        // new entry offered to every cell, stamped with the running insert sequence
        w_ctl.fresh.deadline = r_item.deadline;
        w_ctl.fresh.task_id  = r_item.task_id;
        w_ctl.fresh.order    = r_seq;

        unique case (r_state)
            ST_IDLE: begin
                n_pops = '0;
                if (accept) begin
                    n_state = i_item.action ? ST_TICK : ST_INSERT;
                end
            end

            ST_INSERT: begin
                n_state                = ST_IDLE;
                n_out_valid            = 1'b1;
                n_out.expired_id       = '0;
                n_out.expired_deadline = '0;
                n_out.last             = 1'b1;
                if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                    // full: drop the beat, sequence unchanged
                    n_out.kind = KIND_FULL;
                end else begin
                    w_ctl.op   = CELL_INSERT;
                    n_count    = r_count + CNT_W'(1);
                    n_seq      = r_seq + ORD_W'(1);
                    n_out.kind = KIND_INSERTED;
                end
                n_out.pending = PEND_W'(n_count);
            end

            ST_TICK: begin
                n_out_valid = 1'b1;
                if (head_due) begin
                    // pop the head, row shifts toward it
                    w_ctl.op               = CELL_POP;
                    n_count                = r_count - CNT_W'(1);
                    n_pops                 = POP_W'(r_pops + 1'b1);
                    n_out.kind             = KIND_EXPIRED;
                    n_out.expired_id       = w_entry[0].task_id;
                    n_out.expired_deadline = w_entry[0].deadline;
                    n_out.last             = !next_due;
                    if (!next_due) begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    // only reached on the first cycle of a tick with nothing due
                    n_out.kind             = KIND_NONE;
                    n_out.expired_id       = '0;
                    n_out.expired_deadline = '0;
                    n_out.last             = 1'b1;
                    n_state                = ST_IDLE;
                end
                n_out.pending = PEND_W'(n_count);
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule
